FILE: src/icmp_enc_pkg.sv
// ----------------------------------------------------------------------------
// icmp_enc_pkg
// Shared types, constants and helpers for the ICMP-in-IPv4 encapsulator.
// ----------------------------------------------------------------------------
package icmp_enc_pkg;

  // Sizing
  localparam int unsigned MAX_MSG_BYTES = 2048;
  localparam int unsigned HDR_BYTES     = 20;
  localparam int unsigned ADDR_W        = $clog2(MAX_MSG_BYTES);
  localparam int unsigned LEN_W         = $clog2(MAX_MSG_BYTES + 1);
  localparam int unsigned POS_W         = $clog2(MAX_MSG_BYTES + HDR_BYTES);

  // Fixed header values
  localparam logic [7:0] IPV4_VER_HL = 8'h45;
  localparam logic [7:0] PROTO_ICMP  = 8'h01;
  localparam logic [7:0] TTL_RESET   = 8'd64;

  // Item codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  // Input beat
  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] destination_address;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_packet;
    logic       overflow;
  } out_t;

  // Read-out request from control to the output stage
  typedef struct packed {
    logic       strobe;
    logic       use_ram;
    logic [7:0] data;
    logic       byte_valid;
    logic       eop;
    logic       ovf;
  } rd_req_t;

  // One end-around carry fold of a 17-bit partial sum
  function automatic logic [15:0] fold17(input logic [16:0] s);
    logic [15:0] r;
    r = s[15:0] + 16'(s[16]);
    return r;
  endfunction

  // IPv4 header byte at offset p
  function automatic logic [7:0] hdr_byte(input logic [4:0]  p,
                                          input logic [15:0] total,
                                          input logic [7:0]  ttl,
                                          input logic [15:0] hchk,
                                          input logic [31:0] src,
                                          input logic [31:0] dst);
    logic [7:0] b;
    case (p)
      5'd0:    b = IPV4_VER_HL;
      5'd2:    b = total[15:8];
      5'd3:    b = total[7:0];
      5'd8:    b = ttl;
      5'd9:    b = PROTO_ICMP;
      5'd10:   b = hchk[15:8];
      5'd11:   b = hchk[7:0];
      5'd12:   b = src[31:24];
      5'd13:   b = src[23:16];
      5'd14:   b = src[15:8];
      5'd15:   b = src[7:0];
      5'd16:   b = dst[31:24];
      5'd17:   b = dst[23:16];
      5'd18:   b = dst[15:8];
      5'd19:   b = dst[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/icmp_enc_ram.sv
// ----------------------------------------------------------------------------
// icmp_enc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module icmp_enc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/icmp_enc_hsum.sv
// ----------------------------------------------------------------------------
// icmp_enc_hsum
// IPv4 header checksum: address words summed on the last push beat, the
// fixed words, length and TTL added and folded in the finishing cycle.
// ----------------------------------------------------------------------------
module icmp_enc_hsum
  import icmp_enc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cap_i,
  input  logic [31:0] src_i,
  input  logic [31:0] dst_i,
  input  logic        fin_i,
  input  logic [15:0] total_i,
  input  logic [7:0]  ttl_i,
  output logic [15:0] hchk_o
);

  logic [17:0] part_q, part_d;
  logic [15:0] hchk_q, hchk_d;
  logic [18:0] sum;
  logic [16:0] fold1;

  // Address words
  always_comb begin
    part_d = 18'(src_i[31:16]) + 18'(src_i[15:0]) + 18'(dst_i[31:16]) + 18'(dst_i[15:0]);
  end

  // Remaining words, two folds, invert
  always_comb begin
    sum    = 19'(part_q) + 19'({IPV4_VER_HL, 8'h00}) + 19'(total_i) + 19'({ttl_i, PROTO_ICMP});
    fold1  = 17'(sum[15:0]) + 17'(sum[18:16]);
    hchk_d = ~fold17(fold1);
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hchk_q <= '0;
    end else if (fin_i) begin
      hchk_q <= hchk_d;
    end
  end

  assign hchk_o = hchk_q;

endmodule

FILE: src/icmp_enc_rdout.sv
// ----------------------------------------------------------------------------
// icmp_enc_rdout
// Output stage: holds a read-out request for the RAM latency and merges the
// stored message byte with header and checksum bytes.
// ----------------------------------------------------------------------------
module icmp_enc_rdout
  import icmp_enc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rd_req_t    req_i,
  input  logic [7:0] ram_rdata_i,
  output logic       result_valid_o,
  output out_t       result_o
);

  logic    strobe_q;
  rd_req_t req_q;

  // Strobe is control, the rest is payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= req_i.strobe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.strobe) begin
      req_q <= req_i;
    end
  end

  // Byte source select
  always_comb begin
    result_o.out_byte      = req_q.use_ram ? ram_rdata_i : req_q.data;
    result_o.byte_valid    = req_q.byte_valid;
    result_o.end_of_packet = req_q.eop;
    result_o.overflow      = req_q.ovf;
  end

  assign result_valid_o = strobe_q;

endmodule

FILE: src/icmp_enc_top.sv
// ----------------------------------------------------------------------------
// icmp_ipv4_encapsulator_top
// Collects an ICMP message in a RAM with its running checksum, frames it
// with an IPv4 header and reads the packet out one byte per pull.
// ----------------------------------------------------------------------------
//  Channel  | Ports                          | Beat taken when
//  ---------+--------------------------------+-------------------------------
//  item     | start, busy, item_i            | start && !busy
//  result   | result_valid_o, result_o       | result_valid_o (no stall)
//  config   | cfg_we_i, cfg_wdata_i          | cfg_we_i
//
//  A push marked last is followed by a finishing cycle in which busy is
//  high (header checksum fold). The result of a pull appears in the cycle
//  after acceptance, registered with the RAM read. Pulls may follow each
//  other every cycle while busy is low. No clearing pass after reset: the
//  message RAM is only read at entries written for the current packet.
// ----------------------------------------------------------------------------
module icmp_ipv4_encapsulator_top
  import icmp_enc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_t        item_i,
  output logic       result_valid_o,
  output out_t       result_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // State
  logic [LEN_W-1:0]  len_q, len_d;
  logic [15:0]       sum_q, sum_d;
  logic [15:0]       icmp_q, icmp_d;
  logic [31:0]       src_q, src_d;
  logic [31:0]       dst_q, dst_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              ready_q, ready_d;
  logic              ovf_q, ovf_d;
  logic              fin_q, fin_d;
  logic [7:0]        ttl_q;
  logic [7:0]        fttl_q, fttl_d;

  // Handshake decode
  logic accept, push, pull;
  assign accept = start && !busy;
  assign push   = accept && (item_i.mode == MODE_PUSH);
  assign pull   = accept && (item_i.mode == MODE_PULL);

  // Push path
  logic              clr, room, is_ck;
  logic [LEN_W-1:0]  len_eff;
  logic [15:0]       sum_eff, addend;
  logic [16:0]       sum_raw;

  always_comb begin
    clr     = ready_q || (len_q == '0);
    len_eff = clr ? '0 : len_q;
    sum_eff = clr ? '0 : sum_q;
    room    = len_eff < LEN_W'(MAX_MSG_BYTES);
    is_ck   = (len_eff == LEN_W'(2)) || (len_eff == LEN_W'(3));
    addend  = len_eff[0] ? {8'h00, item_i.data_byte} : {item_i.data_byte, 8'h00};
    sum_raw = 17'(sum_eff) + 17'(is_ck ? 16'h0000 : addend);
  end

  // Packet length and read-out position decode
  logic [15:0]       total, total_m1;
  logic [POS_W-1:0]  msg_pos;
  logic              is_hdr, eop;

  always_comb begin
    total    = 16'(len_q) + 16'(HDR_BYTES);
    total_m1 = 16'(len_q) + 16'(HDR_BYTES - 1);
    msg_pos  = pos_q - POS_W'(HDR_BYTES);
    is_hdr   = pos_q < POS_W'(HDR_BYTES);
    eop      = (16'(pos_q) == total_m1);
  end

  // Header checksum unit
  logic [15:0] hchk;

  icmp_enc_hsum u_hsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cap_i   (push && item_i.last_byte),
    .src_i   (item_i.source_address),
    .dst_i   (item_i.destination_address),
    .fin_i   (fin_q),
    .total_i (total),
    .ttl_i   (ttl_q),
    .hchk_o  (hchk)
  );

  // Read-out request
  rd_req_t req;

  always_comb begin
    req            = '0;
    req.strobe     = pull;
    req.byte_valid = ready_q;
    req.ovf        = ovf_q;
    if (ready_q) begin
      req.eop = eop;
      if (is_hdr) begin
        req.data = hdr_byte(pos_q[4:0], total, fttl_q, hchk, src_q, dst_q);
      end else if (msg_pos == POS_W'(2)) begin
        req.data = icmp_q[15:8];
      end else if (msg_pos == POS_W'(3)) begin
        req.data = icmp_q[7:0];
      end else begin
        req.use_ram = 1'b1;
      end
    end
  end

  // Message store
  logic [7:0] ram_rdata;

  icmp_enc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MSG_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push && room),
    .waddr_i (len_eff[ADDR_W-1:0]),
    .wdata_i (item_i.data_byte),
    .re_i    (pull && req.use_ram),
    .raddr_i (msg_pos[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Output stage
  icmp_enc_rdout u_rdout (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .ram_rdata_i    (ram_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Next state
  always_comb begin
    len_d   = len_q;
    sum_d   = sum_q;
    icmp_d  = icmp_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pos_d   = pos_q;
    ready_d = ready_q;
    ovf_d   = ovf_q;
    fin_d   = 1'b0;
    fttl_d  = fttl_q;

    if (push) begin
      len_d   = len_eff;
      sum_d   = sum_eff;
      ovf_d   = clr ? 1'b0 : ovf_q;
      pos_d   = '0;
      ready_d = 1'b0;
      if (room) begin
        sum_d = fold17(sum_raw);
        len_d = len_eff + LEN_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (item_i.last_byte) begin
        src_d = item_i.source_address;
        dst_d = item_i.destination_address;
        fin_d = 1'b1;
      end
    end else if (pull && ready_q) begin
      if (eop) begin
        ready_d = 1'b0;
        pos_d   = '0;
        len_d   = '0;
        sum_d   = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end

    // Finishing cycle: ICMP checksum, TTL snapshot, packet ready
    if (fin_q) begin
      icmp_d  = ~sum_q;
      fttl_d  = ttl_q;
      pos_d   = '0;
      ready_d = 1'b1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      sum_q   <= '0;
      icmp_q  <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      pos_q   <= '0;
      ready_q <= 1'b0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
      fttl_q  <= TTL_RESET;
    end else begin
      len_q   <= len_d;
      sum_q   <= sum_d;
      icmp_q  <= icmp_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      pos_q   <= pos_d;
      ready_q <= ready_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
      fttl_q  <= fttl_d;
    end
  end

  // TTL register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  assign busy = fin_q;

endmodule

FILE: tb/icmp_ipv4_encapsulator_top_test.sv
// ----------------------------------------------------------------------------
// icmp_ipv4_encapsulator_top_test
// Pushes ICMP messages into the encapsulator and pulls the framed IPv4
// packets back out. Every accepted pull is predicted byte for byte. The
// prediction covers the header, both checksums, the message body and the
// overflow flag. Result beats are then checked in order.
// ----------------------------------------------------------------------------
import icmp_enc_pkg::*;

// Tracks the packet under assembly and queues the bytes each pull should see
class frame_tracker;
  logic [7:0]  msg_mem [MAX_MSG_BYTES];
  int unsigned msg_len;
  int unsigned rd_pos;
  logic [31:0] run_sum;
  logic [15:0] icmp_chk;
  logic [15:0] hdr_chk;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  bit          pkt_ready;
  bit          ovf_seen;
  logic [7:0]  ttl_reg;
  logic [7:0]  frame_ttl;
  out_t        due_beats[$];
  int unsigned mismatches;

  function new();
    restart_message();
    icmp_chk   = '0;
    hdr_chk    = '0;
    src_ip     = '0;
    dst_ip     = '0;
    ttl_reg    = TTL_RESET;
    frame_ttl  = TTL_RESET;
    mismatches = 0;
  endfunction

  // end-around carry until the sum fits in 16 bits
  function logic [15:0] fold_sum(input logic [31:0] s);
    while (s[31:16] != 16'h0) s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return s[15:0];
  endfunction

  function void restart_message();
    msg_len   = 0;
    run_sum   = '0;
    rd_pos    = 0;
    pkt_ready = 1'b0;
    ovf_seen  = 1'b0;
  endfunction

  // last byte seen: ICMP checksum, TTL snapshot and header checksum
  function void seal_message();
    logic [15:0] total;
    logic [31:0] h;
    total     = 16'(msg_len + HDR_BYTES);
    icmp_chk  = ~fold_sum(run_sum);
    frame_ttl = ttl_reg;
    h = 32'({IPV4_VER_HL, 8'h00}) + 32'(total) + 32'({frame_ttl, PROTO_ICMP})
      + 32'(src_ip[31:16]) + 32'(src_ip[15:0])
      + 32'(dst_ip[31:16]) + 32'(dst_ip[15:0]);
    hdr_chk   = ~fold_sum(h);
    rd_pos    = 0;
    pkt_ready = 1'b1;
  endfunction

  function logic [7:0] frame_byte(input int unsigned p, input logic [15:0] total);
    int unsigned m;
    if (p < HDR_BYTES) begin
      case (p)
        0:              return IPV4_VER_HL;
        2:              return total[15:8];
        3:              return total[7:0];
        8:              return frame_ttl;
        9:              return PROTO_ICMP;
        10:             return hdr_chk[15:8];
        11:             return hdr_chk[7:0];
        12, 13, 14, 15: return 8'(src_ip >> (8 * (15 - p)));
        16, 17, 18, 19: return 8'(dst_ip >> (8 * (19 - p)));
        default:        return 8'h00;
      endcase
    end
    m = p - HDR_BYTES;
    if (m == 2) return icmp_chk[15:8];
    if (m == 3) return icmp_chk[7:0];
    if (m < MAX_MSG_BYTES) return msg_mem[m];
    return 8'h00;
  endfunction

  // Bytes still to be read from the framed packet
  function int unsigned bytes_left();
    return pkt_ready ? msg_len + HDR_BYTES - rd_pos : 0;
  endfunction

  // Accepted input beat: update state, queue the result a pull produces
  function void note_item(input in_t it);
    out_t        want;
    int unsigned total;
    bit          eop;
    if (it.mode == MODE_PUSH) begin
      if (pkt_ready || msg_len == 0) restart_message();
      if (msg_len < MAX_MSG_BYTES) begin
        msg_mem[msg_len] = it.data_byte;
        // checksum field counts as zero
        if (msg_len != 2 && msg_len != 3)
          run_sum += msg_len[0] ? {24'h0, it.data_byte} : {16'h0, it.data_byte, 8'h00};
        run_sum = {16'h0, fold_sum(run_sum)};
        msg_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (it.last_byte) begin
        src_ip = it.source_address;
        dst_ip = it.destination_address;
        seal_message();
      end
    end else begin
      want          = '0;
      want.overflow = ovf_seen;
      if (pkt_ready) begin
        total              = msg_len + HDR_BYTES;
        eop                = (rd_pos + 1 >= total);
        want.out_byte      = frame_byte(rd_pos, 16'(total));
        want.byte_valid    = 1'b1;
        want.end_of_packet = eop;
        if (eop) begin
          pkt_ready = 1'b0;
          rd_pos    = 0;
          msg_len   = 0;
          run_sum   = '0;
        end else begin
          rd_pos++;
        end
      end
      due_beats.push_back(want);
    end
  endfunction

  // Result beat against the oldest expectation
  function void check_beat(input out_t got);
    out_t want;
    if (due_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat with nothing expected: byte %02h valid %b eop %b ovf %b",
                 got.out_byte, got.byte_valid, got.end_of_packet, got.overflow);
      return;
    end
    want = due_beats.pop_front();
    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
        got.end_of_packet !== want.end_of_packet || got.overflow !== want.overflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp byte/valid/eop/ovf %02h/%b/%b/%b, got %02h/%b/%b/%b",
                 want.out_byte, want.byte_valid, want.end_of_packet, want.overflow,
                 got.out_byte, got.byte_valid, got.end_of_packet, got.overflow);
    end
  endfunction
endclass

module icmp_ipv4_encapsulator_top_test;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 370;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  in_t        item;
  logic       result_valid;
  out_t       result;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  frame_tracker tracker;
  int unsigned  sent_items;
  int unsigned  quiet_cycles;
  bit           fast_lane;

  always #5 clk_i = ~clk_i;

  icmp_ipv4_encapsulator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  // Result check and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid) tracker.check_beat(result);
      if (start && !busy) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("icmp_ipv4_encapsulator_top_test: FAIL");
        $finish;
      end
    end
  end

  // One input beat, with an optional gap in front; noted when taken
  task automatic send_beat(input in_t it);
    int unsigned gap;
    gap = fast_lane ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (!(start && !busy));
    tracker.note_item(it);
    sent_items++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic [31:0] sa, input logic [31:0] da);
    in_t it;
    it.mode                = MODE_PUSH;
    it.data_byte           = b;
    it.last_byte           = last;
    it.source_address      = sa;
    it.destination_address = da;
    send_beat(it);
  endtask

  // Pull beat; the unused fields carry noise
  task automatic pull_byte();
    in_t it;
    it.mode                = MODE_PULL;
    it.data_byte           = 8'($urandom_range(0, 255));
    it.last_byte           = 1'($urandom_range(0, 1));
    it.source_address      = $urandom();
    it.destination_address = $urandom();
    send_beat(it);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // n message bytes, the final one marked last
  task automatic push_message(input int unsigned n);
    logic [31:0] sa;
    logic [31:0] da;
    sa = pick_addr();
    da = pick_addr();
    for (int unsigned i = 0; i < n; i++)
      push_byte(8'($urandom_range(0, 255)), i == n - 1,
                (i == n - 1) ? sa : $urandom(), (i == n - 1) ? da : $urandom());
  endtask

  task automatic pull_bytes(input int unsigned n);
    repeat (n) pull_byte();
  endtask

  // TTL write once the block has gone quiet
  task automatic set_ttl(input logic [7:0] v);
    start <= 1'b0;
    while (tracker.due_beats.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    tracker.ttl_reg = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_ttl();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus
  initial begin
    int unsigned base;
    int unsigned choice;
    int unsigned left;
    tracker      = new();
    rst_ni       = 1'b0;
    start        = 1'b0;
    item         = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    sent_items   = 0;
    quiet_cycles = 0;
    fast_lane    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing framed yet
    pull_byte();
    // one-byte message, extreme addresses, read through to the end
    push_byte(8'hFF, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    pull_bytes(21);
    pull_byte();
    // message summing to all ones gives a zero ICMP checksum
    set_ttl(8'd255);
    push_byte(8'hFF, 1'b0, 32'h0, 32'h0);
    push_byte(8'hFF, 1'b0, 32'h0, 32'h0);
    push_byte(8'h5A, 1'b0, 32'h0, 32'h0);
    push_byte(8'hA5, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    // TTL change after completion must not reach the framed packet
    set_ttl(8'd0);
    pull_bytes(24);

    // Random traffic: mostly whole messages, some noise and broken ones
    base = sent_items;
    while (sent_items < base + RANDOM_ITEMS) begin
      choice    = $urandom_range(0, 99);
      fast_lane = ($urandom_range(0, 3) == 0);
      if (choice < 8) begin
        set_ttl(pick_ttl());
      end else if (choice < 20) begin
        pull_bytes($urandom_range(1, 3));
      end else if (choice < 30) begin
        // unfinished message interrupted by pulls; later pushes extend it
        repeat ($urandom_range(1, 5))
          push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom(), $urandom());
        pull_bytes($urandom_range(1, 2));
      end else begin
        push_message(($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                 : $urandom_range(1, 48));
        left = tracker.bytes_left();
        choice = $urandom_range(0, 99);
        if (choice < 60) pull_bytes(left + $urandom_range(0, 2));
        else if (choice < 85) pull_bytes($urandom_range(0, left - 1));
      end
    end

    // short message read through, one pull past the end
    fast_lane = 1'b0;
    push_message(5);
    pull_bytes(tracker.bytes_left() + 1);

    start <= 1'b0;
    while (tracker.due_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("icmp_ipv4_encapsulator_top_test: PASS");
    end else begin
      $display("icmp_ipv4_encapsulator_top_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/icmp_enc_pkg.sv
src/icmp_enc_ram.sv
src/icmp_enc_hsum.sv
src/icmp_enc_rdout.sv
src/icmp_enc_top.sv
tb/icmp_ipv4_encapsulator_top_test.sv
